### hdl/keypad_code_lock_macros.svh
// Assertion macros used by the lock core RTL.
`ifndef KEYPAD_CODE_LOCK_MACROS_SVH
`define KEYPAD_CODE_LOCK_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define KCL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define KCL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/kcl_pkg.sv
`timescale 1ns / 1ps

package kcl_pkg;

   localparam int CODE_W     = 36;
   localparam int HOLD_W     = 16;
   localparam int ELAPSED_W  = 17;
   localparam int KEY_W      = 4;
   localparam int ENTERED_W  = 4;
   localparam int CSR_IDX_W  = 2;

   localparam logic [HOLD_W-1:0]    HOLD_RESET  = 16'd6000;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;

   localparam logic [KEY_W-1:0] KEY_CLEAR = 4'd12;
   localparam logic [KEY_W-1:0] KEY_ENTER = 4'd15;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_KEY  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      VERDICT_NONE   = 2'd0,
      VERDICT_ACCEPT = 2'd1,
      VERDICT_REJECT = 2'd2
   } verdict_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CODE_FIRST  = 2'd0,
      CSR_CODE_SECOND = 2'd1,
      CSR_HOLD_TICKS  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             command;
      logic [KEY_W-1:0] key;
   } req_payload_type;

   typedef struct packed {
      logic                 open;
      logic [ENTERED_W-1:0] entered;
      logic [1:0]           verdict;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [CODE_W-1:0]    data;
   } csr_payload_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_first;
      logic [CODE_W-1:0] code_second;
      logic [HOLD_W-1:0] hold_ticks;
   } cfg_type;

endpackage

### hdl/kcl_stream_if.sv
`timescale 1ns / 1ps

interface kcl_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hdl/kcl_csr_regs.sv
`timescale 1ns / 1ps

module kcl_csr_regs (
   input  logic             clock,
   input  logic             reset,
   kcl_stream_if.sink       csr_chan,
   output kcl_pkg::cfg_type cfg
);

   kcl_pkg::cfg_type cfg_ff;
   kcl_pkg::cfg_type cfg_in;
   logic             csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (kcl_pkg::csr_index_type'(csr_chan.payload.index))
            kcl_pkg::CSR_CODE_FIRST: begin
               cfg_in.code_first = csr_chan.payload.data;
            end
            kcl_pkg::CSR_CODE_SECOND: begin
               cfg_in.code_second = csr_chan.payload.data;
            end
            kcl_pkg::CSR_HOLD_TICKS: begin
               cfg_in.hold_ticks = csr_chan.payload.data[kcl_pkg::HOLD_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_first  <= '0;
         cfg_ff.code_second <= '0;
         cfg_ff.hold_ticks  <= kcl_pkg::HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/kcl_lock_core.sv
`timescale 1ns / 1ps
`include "keypad_code_lock_macros.svh"

module kcl_lock_core #(
   parameter int CODE_LENGTH = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  kcl_pkg::req_payload_type item,
   input  kcl_pkg::cfg_type         cfg,
   output kcl_pkg::rsp_payload_type result
);

   localparam int CNT_W = $clog2(CODE_LENGTH + 1);
   localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CODE_LENGTH);

   logic [kcl_pkg::KEY_W-1:0]     entry_ff [CODE_LENGTH];
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic                          open_ff;
   logic                          open_in;
   logic [kcl_pkg::ELAPSED_W-1:0] elapsed_ff;
   logic [kcl_pkg::ELAPSED_W-1:0] elapsed_in;
   logic [kcl_pkg::ELAPSED_W-1:0] elapsed_inc;

   logic [kcl_pkg::KEY_W-1:0] first_nib  [CODE_LENGTH];
   logic [kcl_pkg::KEY_W-1:0] second_nib [CODE_LENGTH];
   logic [CODE_LENGTH-1:0]    eq_first;
   logic [CODE_LENGTH-1:0]    eq_second;
   logic                      entry_full;
   logic                      code_ok;
   logic                      key_store;
   kcl_pkg::verdict_type      verdict;

   for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_nib
      if (4 * i + 4 <= kcl_pkg::CODE_W) begin : g_code
         assign first_nib[i]  = cfg.code_first[4*i +: 4];
         assign second_nib[i] = cfg.code_second[4*i +: 4];
      end else begin : g_zero
         assign first_nib[i]  = '0;
         assign second_nib[i] = '0;
      end
      assign eq_first[i]  = (entry_ff[i] == first_nib[i]);
      assign eq_second[i] = (entry_ff[i] == second_nib[i]);
   end

   assign entry_full  = (count_ff == FULL_COUNT);
   assign code_ok     = entry_full && ((&eq_first) || (&eq_second));
   assign elapsed_inc = (elapsed_ff < kcl_pkg::ELAPSED_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;

   always_comb begin
      count_in   = count_ff;
      open_in    = open_ff;
      elapsed_in = elapsed_ff;
      key_store  = 1'b0;
      verdict    = kcl_pkg::VERDICT_NONE;
      if (item.command == kcl_pkg::CMD_TICK) begin
         if (open_ff) begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc > {1'b0, cfg.hold_ticks}) begin
               open_in    = 1'b0;
               elapsed_in = '0;
            end
         end
      end else if (!open_ff) begin
         if (item.key == kcl_pkg::KEY_ENTER) begin
            if (code_ok) begin
               open_in    = 1'b1;
               elapsed_in = '0;
               verdict    = kcl_pkg::VERDICT_ACCEPT;
            end else begin
               verdict    = kcl_pkg::VERDICT_REJECT;
            end
            count_in = '0;
         end else if (item.key == kcl_pkg::KEY_CLEAR) begin
            count_in = '0;
         end else if (count_ff < FULL_COUNT) begin
            key_store = 1'b1;
            count_in  = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         open_ff    <= 1'b0;
         elapsed_ff <= '0;
      end else if (step) begin
         count_ff   <= count_in;
         open_ff    <= open_in;
         elapsed_ff <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
         if (step && key_store && count_ff[IDX_W-1:0] == IDX_W'(i)) begin
            entry_ff[i] <= item.key;
         end
      end
   end

   assign result.open    = open_in;
   assign result.entered = kcl_pkg::ENTERED_W'(count_in);
   assign result.verdict = verdict;

   `KCL_ASSERT(a_count_bound, clock, reset, count_ff <= FULL_COUNT, "entry count past code length")
   `KCL_ASSERT(a_open_clears_entry, clock, reset, $rose(open_ff) |-> count_ff == '0, "lock opened with entry held")
   `KCL_ASSERT(a_close_on_tick, clock, reset, $fell(open_ff) |-> $past(step) && $past(item.command) == kcl_pkg::CMD_TICK, "lock closed without a tick")
   `KCL_ASSERT(a_accept_opens, clock, reset, step && verdict == kcl_pkg::VERDICT_ACCEPT |=> open_ff && elapsed_ff == '0, "accept did not open the lock")

endmodule

### hdl/keypad_code_lock.sv
`timescale 1ns / 1ps
// Channel    Dir  Payload                        Handshake
// req_chan   in   command, key                   valid / ready
// rsp_chan   out  open, entered, verdict         valid / ready
// csr_chan   in   index, data (code / hold)      valid / ready, always ready
//
// Pipeline: req is held in the input register, then the result register drives rsp.
// Throughput: one item per cycle unless rsp stalls; state updates in one core step.
// Reset: synchronous; clears lock state, pipeline valids, codes; hold_ticks to 6000.
// Stalls: a held rsp keeps one further item in the input register, then req_chan drops ready.

module keypad_code_lock #(
   parameter int CODE_LENGTH = 9
) (
   input logic          clock,
   input logic          reset,
   kcl_stream_if.sink   req_chan,
   kcl_stream_if.source rsp_chan,
   kcl_stream_if.sink   csr_chan
);

   logic                     in_valid_ff;
   kcl_pkg::req_payload_type in_item_ff;
   logic                     out_valid_ff;
   kcl_pkg::rsp_payload_type out_item_ff;
   kcl_pkg::rsp_payload_type core_result;
   kcl_pkg::cfg_type         cfg;
   logic                     advance;
   logic                     req_take;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   kcl_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   kcl_lock_core #(
      .CODE_LENGTH (CODE_LENGTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_chan.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_item_ff;

endmodule
